// ===== rtl/rmvp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmvp_pkg
// Shared widths, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package rmvp_pkg;

	localparam int COUNT_W = 20;
	localparam int FRAC_W  = 16;
	localparam int DATA_W  = 32;
	localparam int VAR_W   = 48;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_COUNT,
		OP_CLEAR,
		OP_DIV_DELTA,
		OP_MEAN,
		OP_MUL_AB,
		OP_PROD,
		OP_DIV_Q,
		OP_VAR,
		OP_MUL_RDM,
		OP_DIV_MD,
		OP_MPOST,
		OP_MUL_T,
		OP_SUM,
		OP_MUL_PS,
		OP_FINAL
	} op_t;

	typedef struct packed {
		op_t  op;
		logic capture;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic no_update;
		logic cnt_zero;
		logic mul_busy;
		logic div_busy;
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0]        strength;
		logic signed [DATA_W-1:0] mean;
		logic [DATA_W-1:0]        scale;
	} prior_t;

endpackage

// ===== rtl/rmvp_regs.sv =====
// ----------------------------------------------------------------------------
// rmvp_regs
// APB-style register file holding the prior hyperparameters.
// ----------------------------------------------------------------------------
module rmvp_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output rmvp_pkg::prior_t  prior
);
	import rmvp_pkg::*;

	localparam logic [1:0] REG_STRENGTH = 2'd0;
	localparam logic [1:0] REG_MEAN     = 2'd1;
	localparam logic [1:0] REG_SCALE    = 2'd2;

	logic [31:0] strength_q;
	logic [31:0] mean_q;
	logic [31:0] scale_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= 32'd65536;
			mean_q     <= 32'd0;
			scale_q    <= 32'd65536;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_STRENGTH: strength_q <= pwdata;
				REG_MEAN:     mean_q     <= pwdata;
				REG_SCALE:    scale_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_STRENGTH: prdata = strength_q;
			REG_MEAN:     prdata = mean_q;
			REG_SCALE:    prdata = scale_q;
			default:      prdata = 32'd0;
		endcase
	end

	assign prior.strength = strength_q;
	assign prior.mean     = $signed(mean_q);
	assign prior.scale    = scale_q;

endmodule

// ===== rtl/rmvp_dp.sv =====
// ----------------------------------------------------------------------------
// rmvp_dp
// Datapath: running statistics, shared 2-step multiplier, bit-serial divider.
// ----------------------------------------------------------------------------
module rmvp_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rmvp_pkg::cmd_t                      cmd,
	input  rmvp_pkg::prior_t                    prior,
	input  logic signed [rmvp_pkg::DATA_W-1:0]  sample,
	input  logic signed [1:0]                   weight,
	output rmvp_pkg::status_t                   status,
	output logic [rmvp_pkg::COUNT_W-1:0]        count,
	output logic signed [rmvp_pkg::DATA_W-1:0]  mean_out,
	output logic [rmvp_pkg::VAR_W-1:0]          variance_out,
	output logic signed [rmvp_pkg::DATA_W-1:0]  post_mean,
	output logic [rmvp_pkg::VAR_W-1:0]          post_scale,
	output logic                                error_flag
);
	import rmvp_pkg::*;

	localparam logic [1:0] W_ADD = 2'b01;
	localparam logic [1:0] W_REM = 2'b11;
	localparam logic [COUNT_W-1:0] CNT_MAX = '1;
	localparam logic [VAR_W-1:0]   VAR_MAX = '1;

	// architectural state
	logic [COUNT_W-1:0]        cnt_q;
	logic signed [31:0]        mean_q;
	logic [VAR_W-1:0]          var_q;
	logic                      inc_q, dec_q, err_q;
	logic [1:0]                mcnt_q;
	logic [6:0]                dcnt_q;

	// working registers
	logic signed [31:0]        x_q;
	logic [1:0]                wt_q;
	logic signed [33:0]        a_q, b_q;
	logic signed [64:0]        diff_q;
	logic [31:0]               mp_q;
	logic [VAR_W-1:0]          sum_q, ps_q;
	logic [47:0]               ma_q;
	logic [33:0]               mb_q;
	logic [81:0]               prod_q;
	logic [63:0]               dvd_q, quo_q;
	logic [36:0]               drem_q, dsr_q;

	// combinational
	logic                      cnt_zero;
	logic [31:0]               r_eff;
	logic signed [33:0]        d_post, b_now, a_now;
	logic [32:0]               dm, a_mag, b_mag;
	logic [36:0]               den;
	logic signed [34:0]        dq, nm35;
	logic                      nm_ovf;
	logic signed [31:0]        nm_sat;
	logic [48:0]               pm;
	logic signed [64:0]        p65, diff_now;
	logic [63:0]               diff_mag;
	logic signed [65:0]        sq, nv;
	logic [32:0]               md;
	logic signed [33:0]        mp34;
	logic                      t_ovf, ps_ovf;
	logic [VAR_W-1:0]          t_val, psb;
	logic [48:0]               sum49, tot49;
	logic [64:0]               pp;
	logic [37:0]               dsh;
	logic [38:0]               dsub;

	assign cnt_zero = (cnt_q == '0);
	assign r_eff    = (prior.strength == 32'd0) ? 32'd1 : prior.strength;
	assign d_post   = 34'($signed(prior.mean)) - 34'(mean_q);
	assign dm       = d_post[33] ? 33'(-d_post) : 33'(d_post);
	assign den      = 37'(r_eff) + (37'(cnt_q) << FRAC_W);
	assign b_now    = 34'(x_q) - 34'(mean_q);
	assign a_mag    = a_q[33] ? 33'(-a_q) : 33'(a_q);
	assign b_mag    = b_q[33] ? 33'(-b_q) : 33'(b_q);

	assign dq     = b_q[33] ? -$signed({2'b00, quo_q[32:0]}) : $signed({2'b00, quo_q[32:0]});
	assign nm35   = inc_q ? 35'(mean_q) + dq : 35'(mean_q) - dq;
	assign nm_ovf = !((nm35[34:31] == 4'b0000) || (nm35[34:31] == 4'b1111));
	assign nm_sat = nm_ovf ? (nm35[34] ? 32'sh8000_0000 : 32'sh7fff_ffff)
	                       : $signed(nm35[31:0]);
	assign a_now  = 34'(x_q) - 34'(nm_sat);

	assign pm       = prod_q[64:16];
	assign p65      = (a_q[33] ^ b_q[33]) ? -$signed({16'd0, pm}) : $signed({16'd0, pm});
	assign diff_now = p65 - $signed({17'd0, var_q});
	assign diff_mag = diff_q[64] ? 64'(-diff_q) : 64'(diff_q);

	assign sq = diff_q[64] ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign nv = inc_q ? $signed({18'd0, var_q}) + sq : $signed({18'd0, var_q}) - sq;

	assign md   = quo_q[32:0];
	assign mp34 = d_post[33] ? 34'(mean_q) - $signed({1'b0, md})
	                         : 34'(mean_q) + $signed({1'b0, md});

	assign t_ovf  = (prod_q[81:64] != '0);
	assign t_val  = t_ovf ? VAR_MAX : prod_q[63:16];
	assign sum49  = {1'b0, var_q} + {1'b0, t_val};
	assign ps_ovf = (prod_q[81:48] != '0);
	assign psb    = cnt_zero ? '0 : (ps_ovf ? VAR_MAX : prod_q[47:0]);
	assign tot49  = {1'b0, psb} + 49'(prior.scale);

	assign pp   = ma_q * mb_q[33:17];
	assign dsh  = {drem_q, dvd_q[63]};
	assign dsub = {1'b0, dsh} - {2'b00, dsr_q};

	assign status.no_update = !inc_q && !dec_q;
	assign status.cnt_zero  = cnt_zero;
	assign status.mul_busy  = (mcnt_q != '0);
	assign status.div_busy  = (dcnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mean_q <= '0;
			var_q  <= '0;
			inc_q  <= 1'b0;
			dec_q  <= 1'b0;
			err_q  <= 1'b0;
			mcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (mcnt_q != '0)
				mcnt_q <= mcnt_q - 2'd1;
			if (dcnt_q != '0)
				dcnt_q <= dcnt_q - 7'd1;
			case (cmd.op)
				OP_LOAD: begin
					inc_q <= (wt_q == W_ADD) && (cnt_q != CNT_MAX);
					dec_q <= (wt_q == W_REM) && !cnt_zero;
					err_q <= ((wt_q == W_ADD) && (cnt_q == CNT_MAX)) ||
					         ((wt_q == W_REM) && cnt_zero);
				end
				OP_COUNT: cnt_q <= inc_q ? cnt_q + 1'b1 : cnt_q - 1'b1;
				OP_CLEAR: begin
					mean_q <= '0;
					var_q  <= '0;
				end
				OP_MEAN: begin
					mean_q <= nm_sat;
					if (nm_ovf)
						err_q <= 1'b1;
				end
				OP_VAR: begin
					if (nv[65])
						var_q <= '0;
					else if (nv[64:48] != '0) begin
						var_q <= VAR_MAX;
						err_q <= 1'b1;
					end else
						var_q <= nv[47:0];
				end
				OP_SUM: begin
					if (t_ovf || sum49[48])
						err_q <= 1'b1;
				end
				OP_FINAL: begin
					if ((!cnt_zero && ps_ovf) || tot49[48])
						err_q <= 1'b1;
				end
				OP_DIV_DELTA: dcnt_q <= 7'd33;
				OP_DIV_Q:     dcnt_q <= 7'd63;
				OP_DIV_MD:    dcnt_q <= 7'd64;
				OP_MUL_AB, OP_MUL_RDM, OP_MUL_T, OP_MUL_PS: mcnt_q <= 2'd2;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q  <= sample;
			wt_q <= weight;
		end
		if (mcnt_q != '0) begin
			prod_q <= (prod_q << 17) + 82'(pp);
			mb_q   <= mb_q << 17;
		end
		if (dcnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			if (!dsub[38]) begin
				drem_q <= dsub[36:0];
				quo_q  <= {quo_q[62:0], 1'b1};
			end else begin
				drem_q <= dsh[36:0];
				quo_q  <= {quo_q[62:0], 1'b0};
			end
		end
		case (cmd.op)
			OP_DIV_DELTA: begin
				b_q    <= b_now;
				dvd_q  <= {(b_now[33] ? 33'(-b_now) : 33'(b_now)), 31'd0};
				dsr_q  <= 37'(cnt_q);
				drem_q <= '0;
				quo_q  <= '0;
			end
			OP_MEAN: a_q <= a_now;
			OP_MUL_AB: begin
				ma_q   <= 48'(a_mag);
				mb_q   <= 34'(b_mag);
				prod_q <= '0;
			end
			OP_PROD: diff_q <= diff_now;
			OP_DIV_Q: begin
				dvd_q  <= {diff_mag[62:0], 1'b0};
				dsr_q  <= 37'(cnt_q);
				drem_q <= '0;
				quo_q  <= '0;
			end
			OP_MUL_RDM: begin
				ma_q   <= 48'(r_eff);
				mb_q   <= 34'(dm);
				prod_q <= '0;
			end
			OP_DIV_MD: begin
				dvd_q  <= prod_q[63:0];
				dsr_q  <= den;
				drem_q <= '0;
				quo_q  <= '0;
			end
			OP_MPOST: mp_q <= mp34[31:0];
			OP_MUL_T: begin
				ma_q   <= 48'(dm);
				mb_q   <= 34'(md);
				prod_q <= '0;
			end
			OP_SUM: sum_q <= sum49[48] ? VAR_MAX : sum49[47:0];
			OP_MUL_PS: begin
				ma_q   <= sum_q;
				mb_q   <= 34'(cnt_q);
				prod_q <= '0;
			end
			OP_FINAL: ps_q <= tot49[48] ? VAR_MAX : tot49[47:0];
			default: ;
		endcase
		if (cmd.emit) begin
			count        <= cnt_q;
			mean_out     <= mean_q;
			variance_out <= var_q;
			post_mean    <= $signed(mp_q);
			post_scale   <= ps_q;
			error_flag   <= err_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIV_DELTA || cmd.op == OP_DIV_Q || cmd.op == OP_DIV_MD)
		|-> dcnt_q == '0)
		else $error("divider started while busy");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MUL_AB || cmd.op == OP_MUL_RDM || cmd.op == OP_MUL_T ||
		 cmd.op == OP_MUL_PS) |-> mcnt_q == '0)
		else $error("multiplier started while busy");
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_COUNT |=> cnt_q != $past(cnt_q))
		else $error("count update did not change count");
`endif

endmodule

// ===== rtl/rmvp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmvp_ctrl
// Sequencer: steps the datapath through update and posterior operations.
// ----------------------------------------------------------------------------
module rmvp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rmvp_pkg::status_t status,
	output rmvp_pkg::cmd_t    cmd
);
	import rmvp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_DECIDE, S_COUNT, S_CHECK, S_CLEAR,
		S_DIVD, W_DIVD, S_MEAN, S_MAB, W_MAB, S_PROD, S_DIVQ, W_DIVQ, S_VAR,
		S_MRDM, W_MRDM, S_DIVMD, W_DIVMD, S_MPOST, S_MT, W_MT, S_SUM,
		S_MPS, W_MPS, S_FINAL, S_WAIT
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   in_ready_q, out_valid_q;
	logic   in_fire, emit;

	assign in_fire     = in_valid && in_ready_q;
	assign emit        = (state_q == S_WAIT) && (!out_valid_q || out_ready);
	assign in_ready    = in_ready_q;
	assign out_valid   = out_valid_q;
	assign cmd.op      = op_q;
	assign cmd.capture = in_fire;
	assign cmd.emit    = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NONE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			op_q <= OP_NONE;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					state_q    <= S_LOAD;
					op_q       <= OP_LOAD;
					in_ready_q <= 1'b0;
				end
				S_LOAD: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (status.no_update) begin
						state_q <= S_MRDM;
						op_q    <= OP_MUL_RDM;
					end else begin
						state_q <= S_COUNT;
						op_q    <= OP_COUNT;
					end
				end
				S_COUNT: state_q <= S_CHECK;
				S_CHECK: begin
					if (status.cnt_zero) begin
						state_q <= S_CLEAR;
						op_q    <= OP_CLEAR;
					end else begin
						state_q <= S_DIVD;
						op_q    <= OP_DIV_DELTA;
					end
				end
				S_CLEAR: begin
					state_q <= S_MRDM;
					op_q    <= OP_MUL_RDM;
				end
				S_DIVD: state_q <= W_DIVD;
				W_DIVD: if (!status.div_busy) begin
					state_q <= S_MEAN;
					op_q    <= OP_MEAN;
				end
				S_MEAN: begin
					state_q <= S_MAB;
					op_q    <= OP_MUL_AB;
				end
				S_MAB: state_q <= W_MAB;
				W_MAB: if (!status.mul_busy) begin
					state_q <= S_PROD;
					op_q    <= OP_PROD;
				end
				S_PROD: begin
					state_q <= S_DIVQ;
					op_q    <= OP_DIV_Q;
				end
				S_DIVQ: state_q <= W_DIVQ;
				W_DIVQ: if (!status.div_busy) begin
					state_q <= S_VAR;
					op_q    <= OP_VAR;
				end
				S_VAR: begin
					state_q <= S_MRDM;
					op_q    <= OP_MUL_RDM;
				end
				S_MRDM: state_q <= W_MRDM;
				W_MRDM: if (!status.mul_busy) begin
					state_q <= S_DIVMD;
					op_q    <= OP_DIV_MD;
				end
				S_DIVMD: state_q <= W_DIVMD;
				W_DIVMD: if (!status.div_busy) begin
					state_q <= S_MPOST;
					op_q    <= OP_MPOST;
				end
				S_MPOST: begin
					if (status.cnt_zero) begin
						state_q <= S_FINAL;
						op_q    <= OP_FINAL;
					end else begin
						state_q <= S_MT;
						op_q    <= OP_MUL_T;
					end
				end
				S_MT: state_q <= W_MT;
				W_MT: if (!status.mul_busy) begin
					state_q <= S_SUM;
					op_q    <= OP_SUM;
				end
				S_SUM: begin
					state_q <= S_MPS;
					op_q    <= OP_MUL_PS;
				end
				S_MPS: state_q <= W_MPS;
				W_MPS: if (!status.mul_busy) begin
					state_q <= S_FINAL;
					op_q    <= OP_FINAL;
				end
				S_FINAL: state_q <= S_WAIT;
				S_WAIT: if (emit) begin
					state_q     <= S_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_fire_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_LOAD) && !in_ready_q)
		else $error("accepted transfer did not start a load");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result emitted without output valid");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> in_ready_q)
		else $error("idle without input ready");
`endif

endmodule

// ===== rtl/running_mean_variance_posterior_core.sv =====
// Each item runs through the 1-bit-per-cycle divider (33, 63 or 64 steps per division)
// and the 2-step 48x17 multiplier.
// One item in flight; input ready returns when the result registers, with output valid.
// Reset: asynchronous, clears count, mean and variance, priors to 1.0/0/1.0.
// ----------------------------------------------------------------------------
// running_mean_variance_posterior_core
// Weighted running mean/variance with normal-inverse-gamma posterior outputs.
// ----------------------------------------------------------------------------
module running_mean_variance_posterior_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [rmvp_pkg::DATA_W-1:0]  sample,
	input  logic signed [1:0]                   weight,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rmvp_pkg::COUNT_W-1:0]        count,
	output logic signed [rmvp_pkg::DATA_W-1:0]  mean_out,
	output logic [rmvp_pkg::VAR_W-1:0]          variance_out,
	output logic signed [rmvp_pkg::DATA_W-1:0]  post_mean,
	output logic [rmvp_pkg::VAR_W-1:0]          post_scale,
	output logic                                error_flag
);
	import rmvp_pkg::*;

	prior_t  prior;
	cmd_t    cmd;
	status_t status;

	rmvp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.prior   (prior)
	);

	rmvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rmvp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.prior        (prior),
		.sample       (sample),
		.weight       (weight),
		.status       (status),
		.count        (count),
		.mean_out     (mean_out),
		.variance_out (variance_out),
		.post_mean    (post_mean),
		.post_scale   (post_scale),
		.error_flag   (error_flag)
	);

endmodule

// ===== test/running_mean_variance_posterior_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_mean_variance_posterior_core_tb
// Checks the running mean/variance core against a cycle-free fixed point
// predictor: adds, removes, queries, empty removals and saturation, over
// several prior settings written through APB, with random stalls on both sides.
// ----------------------------------------------------------------------------
module running_mean_variance_posterior_core_tb;
	import rmvp_pkg::*;

	localparam logic [3:0] ADDR_STRENGTH = 4'd0;
	localparam logic [3:0] ADDR_MEAN     = 4'd4;
	localparam logic [3:0] ADDR_SCALE    = 4'd8;
	localparam logic [1:0] W_ADD    = 2'b01;
	localparam logic [1:0] W_REMOVE = 2'b11;
	localparam logic [1:0] W_QUERY  = 2'b00;
	localparam logic [1:0] W_ODD    = 2'b10;
	localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned CAP62 = 64'h4000_0000_0000_0000;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic signed [DATA_W-1:0] x;
		logic [1:0]               w;
	} sample_item_t;

	typedef struct {
		logic [COUNT_W-1:0] cnt;
		logic [DATA_W-1:0]  mean;
		logic [VAR_W-1:0]   vari;
		logic [DATA_W-1:0]  pmean;
		logic [VAR_W-1:0]   pscale;
		logic               err;
	} stats_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [DATA_W-1:0] sample;
	logic signed [1:0] weight;
	logic [COUNT_W-1:0] count;
	logic signed [DATA_W-1:0] mean_out, post_mean;
	logic [VAR_W-1:0] variance_out, post_scale;
	logic error_flag;

	running_mean_variance_posterior_core dut (.*);

	sample_item_t pend_q[$];
	stats_t stats_q[$];
	logic signed [DATA_W-1:0] held[$];

	// predictor state and priors
	longint unsigned held_cnt;
	longint mu, var_acc;
	logic [31:0] pri_r, pri_m, pri_s;

	int fails, n_in, n_out, n_err_seen, n_add, n_rem;
	int tx_idle, rx_idle;
	bit tx_hold, rx_hold_req;
	int idle_cycles;
	sample_item_t cur;

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned mulshr_cap(longint unsigned a, longint unsigned b,
			longint unsigned cap, inout bit sat);
		logic [127:0] p;
		p = (128'(a) * 128'(b)) >> FRAC_W;
		if (p > 128'(cap)) begin
			sat = 1;
			return cap;
		end
		return p[63:0];
	endfunction

	function automatic longint unsigned mul_cap(longint unsigned a, longint unsigned b,
			longint unsigned cap, inout bit sat);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		if (p > 128'(cap)) begin
			sat = 1;
			return cap;
		end
		return p[63:0];
	endfunction

	function automatic stats_t welford_update(sample_item_t it);
		stats_t s;
		longint x, n, om, delta, nm, a, b, p, q, nv, m, d, mp;
		longint unsigned r, dm, den, md, t, sum, ps, pm, cmax;
		logic [127:0] num;
		int w;
		bit err, sat;
		x = it.x;
		w = it.w == W_ADD ? 1 : (it.w == W_REMOVE ? -1 : 0);
		cmax = (64'd1 << COUNT_W) - 1;
		err = 0;
		if (w == 1 && held_cnt >= cmax) begin
			err = 1;
			w = 0;
		end
		if (w == -1 && held_cnt == 0) begin
			err = 1;
			w = 0;
		end
		if (w != 0) begin
			held_cnt = w > 0 ? held_cnt + 1 : held_cnt - 1;
			if (held_cnt == 0) begin
				mu = 0;
				var_acc = 0;
			end else begin
				n = held_cnt;
				om = mu;
				delta = (x - om) / n;
				nm = w > 0 ? om + delta : om - delta;
				if (nm > 64'sd2147483647) begin
					nm = 64'sd2147483647;
					err = 1;
				end
				if (nm < -64'sd2147483648) begin
					nm = -64'sd2147483648;
					err = 1;
				end
				a = x - nm;
				b = x - om;
				pm = mulshr_cap(magn(a), magn(b), CAP62, err);
				p = ((a < 0) != (b < 0)) ? -longint'(pm) : longint'(pm);
				q = (p - var_acc) / n;
				nv = w > 0 ? var_acc + q : var_acc - q;
				if (nv > longint'(MAX48)) begin
					nv = longint'(MAX48);
					err = 1;
				end
				if (nv < 0)
					nv = 0;
				mu = nm;
				var_acc = nv;
			end
		end
		r = pri_r != 0 ? 64'(pri_r) : 64'd1;
		m = longint'(signed'(pri_m));
		d = m - mu;
		dm = magn(d);
		den = r + (held_cnt << FRAC_W);
		num = 128'(r) * 128'(dm);
		num = num / 128'(den);
		md = num[63:0];
		mp = d < 0 ? mu - longint'(md) : mu + longint'(md);
		ps = 0;
		if (held_cnt != 0) begin
			sat = 0;
			t = mulshr_cap(dm, md, MAX48, sat);
			sum = longint'(var_acc) + t;
			if (sum > MAX48) begin
				sum = MAX48;
				sat = 1;
			end
			ps = mul_cap(held_cnt, sum, MAX48, sat);
			if (sat)
				err = 1;
		end
		ps += 64'(pri_s);
		if (ps > MAX48) begin
			ps = MAX48;
			err = 1;
		end
		s.cnt = held_cnt[COUNT_W-1:0];
		s.mean = mu[31:0];
		s.vari = var_acc[47:0];
		s.pmean = mp[31:0];
		s.pscale = ps[47:0];
		s.err = err;
		return s;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch on result %0d, %s: got %h expected %h", n_out, field, got, want);
		fails++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			sample <= '0;
			weight <= '0;
		end else begin
			if (in_valid && in_ready) begin
				stats_q.insert(stats_q.size(), welford_update(cur));
				n_in++;
			end
			if (!in_valid || in_ready) begin
				if (pend_q.size() != 0 && !tx_hold && $urandom_range(0, 99) >= tx_idle) begin
					cur = pend_q.pop_front();
					in_valid <= 1;
					sample <= cur.x;
					weight <= cur.w;
				end else
					in_valid <= 0;
			end
		end
	end

	// monitor
	int rx_hold_left;
	always @(posedge clk or negedge arst_n) begin
		stats_t e;
		if (!arst_n) begin
			out_ready <= 0;
			rx_hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (stats_q.size() == 0) begin
					report_mismatch("unexpected transfer", 0, 0);
				end else begin
					e = stats_q.pop_front();
					if (count !== e.cnt) report_mismatch("count", count, e.cnt);
					if (mean_out !== e.mean) report_mismatch("mean_out", mean_out, e.mean);
					if (variance_out !== e.vari)
						report_mismatch("variance_out", variance_out, e.vari);
					if (post_mean !== e.pmean) report_mismatch("post_mean", post_mean, e.pmean);
					if (post_scale !== e.pscale)
						report_mismatch("post_scale", post_scale, e.pscale);
					if (error_flag !== e.err) report_mismatch("error_flag", error_flag, e.err);
					if (error_flag === 1'b1) n_err_seen++;
				end
				n_out++;
			end
			if (rx_hold_req && rx_hold_left == 0) begin
				rx_hold_left = 700;
				rx_hold_req = 0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 0;
			end else
				out_ready <= $urandom_range(0, 99) >= rx_idle;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAIL running_mean_variance_posterior_core");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic apb_write(logic [3:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (addr)
			ADDR_STRENGTH: pri_r = data;
			ADDR_MEAN:     pri_m = data;
			ADDR_SCALE:    pri_s = data;
			default: ;
		endcase
	endtask

	task automatic set_priors(logic [31:0] r, logic [31:0] m, logic [31:0] s);
		apb_write(ADDR_STRENGTH, r);
		apb_write(ADDR_MEAN, m);
		apb_write(ADDR_SCALE, s);
	endtask

	task automatic push(logic signed [DATA_W-1:0] x, logic [1:0] w);
		sample_item_t it;
		it.x = x;
		it.w = w;
		pend_q.insert(pend_q.size(), it);
	endtask

	function automatic logic signed [DATA_W-1:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
			2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			default: return $signed($urandom_range(0, 32'h0001_0000)) + 32'sh0003_0000;
		endcase
	endfunction

	task automatic push_random(int items);
		int k, sel, idx;
		logic signed [DATA_W-1:0] x;
		for (k = 0; k < items; k++) begin
			sel = $urandom_range(0, 99);
			if (held.size() > 40 && sel < 55)
				sel = 60;
			if (sel < 55) begin
				x = rand_sample();
				held.insert(held.size(), x);
				push(x, W_ADD);
				n_add++;
			end else if (sel < 82 && held.size() != 0) begin
				idx = $urandom_range(0, held.size() - 1);
				push(held[idx], W_REMOVE);
				held.delete(idx);
				n_rem++;
			end else if (sel < 90)
				push(rand_sample(), W_QUERY);
			else if (sel < 94)
				push(rand_sample(), W_ODD);
			else begin
				push(rand_sample(), W_REMOVE);
				n_rem++;
			end
		end
	endtask

	task automatic drain();
		while (pend_q.size() != 0 || stats_q.size() != 0 || in_valid)
			@(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	initial begin
		int ph;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		tx_hold = 0;
		rx_hold_req = 0;
		tx_idle = 11;
		rx_idle = 48;
		fails = 0;
		n_in = 0;
		n_out = 0;
		n_err_seen = 0;
		n_add = 0;
		n_rem = 0;
		idle_cycles = 0;
		held_cnt = 0;
		mu = 0;
		var_acc = 0;
		pri_r = 32'h0001_0000;
		pri_m = 32'h0;
		pri_s = 32'h0001_0000;
		repeat (11) @(posedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty removal, extremes, odd weight, overflow paths
		push(32'sh7FFF_FFFF, W_REMOVE);
		push(32'sh0001_0000, W_QUERY);
		push(32'sh7FFF_FFFF, W_ADD);
		push(-32'sh8000_0000, W_ADD);
		push(32'sh0000_0000, W_ODD);
		push(-32'sh8000_0000, W_REMOVE);
		push(32'sh7FFF_FFFF, W_REMOVE);
		push(32'sh7FFF_FFFF, W_REMOVE);
		push(-32'sh8000_0000, W_ADD);
		push(32'sh7FFF_FFFF, W_REMOVE);
		push(32'sh7FFF_FFFF, W_REMOVE);
		push(32'sh0002_0000, W_ADD);
		push(32'sh0004_0000, W_ADD);
		push(32'sh0000_0001, W_ADD);
		push(32'sh0002_0000, W_REMOVE);
		push(32'sh0004_0000, W_REMOVE);
		push(32'sh0000_0001, W_REMOVE);
		push(-32'sh0000_0001, W_QUERY);
		push(32'sh7FFF_FFFF, W_ADD);
		push(32'sh7FFF_FFFF, W_ADD);
		push(-32'sh8000_0000, W_REMOVE);
		push(32'sh0, W_REMOVE);
		push(32'sh0, W_REMOVE);
		drain();
		held.delete();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_priors(32'd1, 32'h8000_0000, 32'd1);
				1: set_priors(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
				2: set_priors(32'd0, $urandom, $urandom);
				3: set_priors(32'h0004_0000, 32'h0001_8000, 32'h0001_0000);
				4: set_priors($urandom_range(1, 32'h0010_0000), $urandom, $urandom);
				default: set_priors($urandom, $urandom, $urandom_range(1, 32'h0100_0000));
			endcase
			@(negedge clk);
			tx_idle = ph < 2 ? 11 : (ph < 4 ? 48 : 0);
			rx_idle = ph < 2 ? 48 : (ph < 4 ? 11 : 0);
			push_random(300);
			if (ph == 1) begin
				rx_hold_req = 1;
				// sender stops until everything so far is back, then resumes
				while (pend_q.size() > 150)
					@(negedge clk);
				tx_hold = 1;
				while (stats_q.size() != 0 || in_valid)
					@(negedge clk);
				tx_hold = 0;
			end
			drain();
		end

		$display("covered %0d items (%0d adds, %0d removes), %0d results, %0d flagged",
			n_in, n_add, n_rem, n_out, n_err_seen);
		$display("six prior settings incl. strength 0/1/max, mean extremes, scale 1/max");
		if (fails == 0)
			$display("PASS running_mean_variance_posterior_core");
		else
			$display("FAIL running_mean_variance_posterior_core");
		$finish;
	end

endmodule
